### hdl/cacd_pkg.sv
// ----------------------------------------------------------------------------
// Composite artifact colour decoder package
// Shared payload types, decode job type and the colour pair table.
// ----------------------------------------------------------------------------
package cacd_pkg;

  localparam int unsigned QueueDepth = 4;

  localparam logic [7:0] FillByte = 8'hFF;

  typedef struct packed {
    logic [7:0] pixel_byte;
    logic       line_end;
  } in_t;

  typedef struct packed {
    logic [3:0] color_index;
    logic       run_last;
    logic       line_last;
  } out_t;

  // window bits 17..6 of previous, current, next byte
  typedef struct packed {
    logic [11:0] nbhd;
    logic        run_last;
    logic        line_last;
  } job_t;

  typedef struct packed {
    logic push_lo;
    logic push_hi;
  } push_t;

  // {left colour, right colour} per 6-bit neighbourhood
  localparam logic [7:0] PairTable [64] = '{
    8'h00, 8'h00, 8'h08, 8'h03, 8'h57, 8'h57, 8'h12, 8'h1B,
    8'hA8, 8'hAE, 8'hA9, 8'hA9, 8'h44, 8'h4F, 8'hCC, 8'hCF,
    8'h5D, 8'h5D, 8'hD0, 8'hD3, 8'h66, 8'h66, 8'h6F, 8'h6B,
    8'h21, 8'h21, 8'hF9, 8'hF9, 8'hBB, 8'hBB, 8'hFF, 8'hFF,
    8'hE0, 8'hE0, 8'hE8, 8'hE3, 8'h07, 8'h07, 8'h12, 8'h1B,
    8'h98, 8'h9E, 8'h99, 8'h99, 8'hF4, 8'hFF, 8'hCC, 8'hCF,
    8'h3D, 8'h3D, 8'h30, 8'h33, 8'h66, 8'h66, 8'h6F, 8'h6B,
    8'hC1, 8'hC1, 8'hC9, 8'hC9, 8'hFB, 8'hFB, 8'hFF, 8'hFF
  };

endpackage

### hdl/cacd_front.sv
// ----------------------------------------------------------------------------
// Composite artifact colour decoder front end
// Holds the line context and turns each byte into zero, one or two decode jobs.
// ----------------------------------------------------------------------------
module cacd_front (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           in_valid_i,
  output logic           in_ready_o,
  input  cacd_pkg::in_t  in_i,
  input  logic           space_i,
  output cacd_pkg::push_t push_o,
  output cacd_pkg::job_t job_lo_o,
  output cacd_pkg::job_t job_hi_o
);

  logic [7:0] prev_q, prev_d;
  logic [7:0] cur_q, cur_d;
  logic       hold_q, hold_d;
  logic       accept;
  logic [7:0] before_end;
  cacd_pkg::job_t job_mid, job_end;

  assign in_ready_o = space_i;
  assign accept     = in_valid_i && space_i;

  assign before_end = hold_q ? cur_q : prev_q;

  always_comb begin
    job_mid.nbhd      = {prev_q[1:0], cur_q, in_i.pixel_byte[7:6]};
    job_mid.run_last  = !in_i.line_end;
    job_mid.line_last = 1'b0;
    job_end.nbhd      = {before_end[1:0], in_i.pixel_byte, cacd_pkg::FillByte[7:6]};
    job_end.run_last  = 1'b1;
    job_end.line_last = 1'b1;
  end

  always_comb begin
    push_o.push_lo = accept && (hold_q || in_i.line_end);
    push_o.push_hi = accept && hold_q && in_i.line_end;
    job_lo_o       = hold_q ? job_mid : job_end;
    job_hi_o       = job_end;
  end

  always_comb begin
    prev_d = prev_q;
    cur_d  = cur_q;
    hold_d = hold_q;
    if (accept) begin
      cur_d = in_i.pixel_byte;
      if (in_i.line_end) begin
        prev_d = cacd_pkg::FillByte;
        hold_d = 1'b0;
      end else begin
        prev_d = before_end;
        hold_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prev_q <= cacd_pkg::FillByte;
      hold_q <= 1'b0;
    end else begin
      prev_q <= prev_d;
      hold_q <= hold_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cur_q <= cur_d;
  end

endmodule

### hdl/cacd_queue.sv
// ----------------------------------------------------------------------------
// Composite artifact colour decoder job queue
// Short queue taking up to two jobs a cycle and releasing one from its head.
// ----------------------------------------------------------------------------
module cacd_queue #(
  parameter int unsigned Depth = cacd_pkg::QueueDepth
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  cacd_pkg::push_t push_i,
  input  cacd_pkg::job_t  job_lo_i,
  input  cacd_pkg::job_t  job_hi_i,
  output logic            space_o,
  output logic            head_valid_o,
  output cacd_pkg::job_t  head_o,
  input  logic            pop_i
);

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);
  localparam logic [PtrW-1:0] LastPtr = PtrW'(Depth - 1);
  localparam logic [CntW-1:0] SpaceLimit = CntW'(Depth - 2);

  cacd_pkg::job_t mem_q [Depth];

  logic [PtrW-1:0] wp_q, wp_d, wp_next, rp_q, rp_d;
  logic [CntW-1:0] cnt_q, cnt_d;
  logic [1:0]      n_push;

  function automatic logic [PtrW-1:0] bump(input logic [PtrW-1:0] p);
    return (p == LastPtr) ? '0 : p + PtrW'(1);
  endfunction

  assign n_push       = {1'b0, push_i.push_lo} + {1'b0, push_i.push_hi};
  assign wp_next      = bump(wp_q);
  assign space_o      = cnt_q <= SpaceLimit;
  assign head_valid_o = cnt_q != '0;
  assign head_o       = mem_q[rp_q];

  always_comb begin
    wp_d = wp_q;
    if (push_i.push_hi) begin
      wp_d = bump(wp_next);
    end else if (push_i.push_lo) begin
      wp_d = wp_next;
    end
    rp_d  = pop_i ? bump(rp_q) : rp_q;
    cnt_d = cnt_q + CntW'(n_push) - CntW'(pop_i);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q  <= '0;
      rp_q  <= '0;
      cnt_q <= '0;
    end else begin
      wp_q  <= wp_d;
      rp_q  <= rp_d;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i.push_lo) begin
      mem_q[wp_q] <= job_lo_i;
    end
    if (push_i.push_hi) begin
      mem_q[wp_next] <= job_hi_i;
    end
  end

endmodule

### hdl/cacd_back.sv
// ----------------------------------------------------------------------------
// Composite artifact colour decoder back end
// Walks a job's 8 pixels, one table lookup and pixel a cycle unless stalled.
// ----------------------------------------------------------------------------
module cacd_back (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           head_valid_i,
  input  cacd_pkg::job_t head_i,
  output logic           pop_o,
  output logic           out_valid_o,
  input  logic           out_ready_i,
  output cacd_pkg::out_t out_o
);

  logic [2:0]     pix_q, pix_d;
  logic           out_valid_q, out_valid_d;
  cacd_pkg::out_t out_q, out_d;
  logic           advance;
  logic           last_pix;
  logic [5:0]     idx;
  logic [7:0]     pair;

  assign advance  = head_valid_i && (!out_valid_q || out_ready_i);
  assign last_pix = pix_q == 3'd7;
  assign pop_o    = advance && last_pix;

  always_comb begin
    unique case (pix_q[2:1])
      2'd0:    idx = head_i.nbhd[11:6];
      2'd1:    idx = head_i.nbhd[9:4];
      2'd2:    idx = head_i.nbhd[7:2];
      default: idx = head_i.nbhd[5:0];
    endcase
    pair = cacd_pkg::PairTable[idx];
  end

  always_comb begin
    pix_d       = pix_q;
    out_valid_d = out_valid_q;
    out_d       = out_q;
    if (advance) begin
      pix_d             = pix_q + 3'd1;
      out_valid_d       = 1'b1;
      out_d.color_index = pix_q[0] ? pair[3:0] : pair[7:4];
      out_d.run_last    = last_pix && head_i.run_last;
      out_d.line_last   = last_pix && head_i.line_last;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pix_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      pix_q       <= pix_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_q <= out_d;
  end

  assign out_valid_o = out_valid_q;
  assign out_o       = out_q;

endmodule

### hdl/composite_artifact_color_decoder_core.sv
// ----------------------------------------------------------------------------
// Composite artifact colour decoder core
// Turns 1-bit-per-pixel scanline bytes into 4-bit artifact colour indices.
// ----------------------------------------------------------------------------
// Each byte is decoded once its successor arrives, or at once when it carries
// line_end, and yields eight colour indices, leftmost pixel first. The output
// register issues one pixel per cycle while out_ready_i does not stall it; a
// line-end byte that also flushes the held byte produces sixteen pixels. The
// front end keeps accepting bytes while the job queue has room for two decode
// jobs, so input and output stall independently.
module composite_artifact_color_decoder_core #(
  parameter int unsigned QueueDepth = cacd_pkg::QueueDepth
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           in_valid_i,
  output logic           in_ready_o,
  input  cacd_pkg::in_t  in_i,
  output logic           out_valid_o,
  input  logic           out_ready_i,
  output cacd_pkg::out_t out_o
);

  logic            space;
  logic            head_valid;
  logic            pop;
  cacd_pkg::push_t push;
  cacd_pkg::job_t  job_lo, job_hi, head;

  cacd_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .in_i       (in_i),
    .space_i    (space),
    .push_o     (push),
    .job_lo_o   (job_lo),
    .job_hi_o   (job_hi)
  );

  cacd_queue #(
    .Depth (QueueDepth)
  ) u_queue (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_i       (push),
    .job_lo_i     (job_lo),
    .job_hi_i     (job_hi),
    .space_o      (space),
    .head_valid_o (head_valid),
    .head_o       (head),
    .pop_i        (pop)
  );

  cacd_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .head_valid_i (head_valid),
    .head_i       (head),
    .pop_o        (pop),
    .out_valid_o  (out_valid_o),
    .out_ready_i  (out_ready_i),
    .out_o        (out_o)
  );

endmodule
